[design/rde_pkg.sv]
// ----------------------------------------------------------------------------
// rde_pkg
// Shared types, constants and helpers of the radix digit emitter.
// ----------------------------------------------------------------------------
package rde_pkg;

   localparam int VALUE_BITS_DEF = 31;
   localparam int NUMBER_W       = 31;
   localparam int BASE_W         = 8;
   localparam int CHAR_W         = 8;
   localparam int DIGIT_W        = 5;

   localparam logic [BASE_W-1:0]  BASE_MIN  = 8'd2;
   localparam logic [BASE_W-1:0]  BASE_MAX  = 8'd27;
   localparam logic [DIGIT_W-1:0] DEC_LIMIT = 5'd10;
   localparam logic [CHAR_W-1:0]  CHAR_ZERO = 8'h30;
   localparam logic [CHAR_W-1:0]  CHAR_A    = 8'h41;
   localparam logic [CHAR_W-1:0]  CHAR_NONE = 8'h00;

   typedef struct packed {
      logic [NUMBER_W-1:0] number_in;
      logic [BASE_W-1:0]   target_base;
   } req_type;

   typedef struct packed {
      logic [CHAR_W-1:0] digit_char;
      logic              bad_base;
      logic              last_digit;
   } rsp_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_DIV,
      ST_PUSH,
      ST_READ,
      ST_EMIT,
      ST_ERR
   } state_type;

   typedef struct packed {
      logic load;
      logic div_step;
      logic push;
      logic pop;
      logic emit_err;
   } ctrl_cmd_type;

   typedef struct packed {
      logic base_bad;
      logic div_last;
      logic quot_zero;
      logic stack_empty;
   } dp_status_type;

   function automatic logic [CHAR_W-1:0] digit_to_ascii(input logic [DIGIT_W-1:0] d);
      logic [CHAR_W-1:0] c;
      if (d < DEC_LIMIT) begin
         c = CHAR_ZERO + CHAR_W'(d);
      end else begin
         c = CHAR_A + CHAR_W'(d - DEC_LIMIT);
      end
      return c;
   endfunction

endpackage

[design/rde_ram.sv]
// ----------------------------------------------------------------------------
// rde_ram
// Generic single write port, single read port RAM with registered read.
// ----------------------------------------------------------------------------
module rde_ram #(
   parameter int WIDTH = 5,
   parameter int DEPTH = 31
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data_ff
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

endmodule

[design/rde_dp.sv]
// ----------------------------------------------------------------------------
// rde_dp
// Datapath: bit-serial restoring divider, digit stack and result formatting.
// ----------------------------------------------------------------------------
module rde_dp #(
   parameter int VALUE_BITS = rde_pkg::VALUE_BITS_DEF
) (
   input  logic                   clock,
   input  logic                   reset,
   input  rde_pkg::req_type       req_data,
   input  rde_pkg::ctrl_cmd_type  cmd,
   output rde_pkg::dp_status_type status,
   output rde_pkg::rsp_type       rsp_data
);
   import rde_pkg::*;

   localparam int CW  = $clog2(VALUE_BITS + 1);
   localparam int BCW = $clog2(VALUE_BITS);
   localparam int AW  = $clog2(VALUE_BITS);

   logic [VALUE_BITS-1:0] value_ff, value_in, value_load;
   logic [DIGIT_W-1:0]    rem_ff, rem_in;
   logic [DIGIT_W-1:0]    base_ff, base_in;
   logic [BCW-1:0]        bitcnt_ff, bitcnt_in;
   logic [CW-1:0]         count_ff, count_in;
   logic [DIGIT_W:0]      trial;
   logic                  trial_ge;
   logic [CW-1:0]         count_dec;
   logic [AW-1:0]         ram_addr;
   logic [DIGIT_W-1:0]    ram_rdata;

   generate
      if (VALUE_BITS <= NUMBER_W) begin : g_narrow
         assign value_load = req_data.number_in[VALUE_BITS-1:0];
      end else begin : g_wide
         assign value_load = {{(VALUE_BITS-NUMBER_W){1'b0}}, req_data.number_in};
      end
   endgenerate

   assign trial     = {rem_ff, value_ff[VALUE_BITS-1]};
   assign trial_ge  = trial >= {1'b0, base_ff};
   assign count_dec = count_ff - CW'(1);

   always_comb begin
      value_in  = value_ff;
      rem_in    = rem_ff;
      base_in   = base_ff;
      bitcnt_in = bitcnt_ff;
      count_in  = count_ff;
      if (cmd.load) begin
         value_in  = value_load;
         rem_in    = '0;
         base_in   = req_data.target_base[DIGIT_W-1:0];
         bitcnt_in = '0;
         count_in  = '0;
      end
      if (cmd.div_step) begin
         value_in  = {value_ff[VALUE_BITS-2:0], trial_ge};
         rem_in    = trial_ge ? DIGIT_W'(trial - {1'b0, base_ff}) : trial[DIGIT_W-1:0];
         bitcnt_in = bitcnt_ff + BCW'(1);
      end
      if (cmd.push) begin
         rem_in    = '0;
         bitcnt_in = '0;
         count_in  = count_ff + CW'(1);
      end
      if (cmd.pop) begin
         count_in = count_dec;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else begin
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      value_ff  <= value_in;
      rem_ff    <= rem_in;
      base_ff   <= base_in;
      bitcnt_ff <= bitcnt_in;
   end

   assign ram_addr = cmd.push ? count_ff[AW-1:0] : count_dec[AW-1:0];

   rde_ram #(
      .WIDTH (DIGIT_W),
      .DEPTH (VALUE_BITS)
   ) u_stack (
      .clock      (clock),
      .wr_en      (cmd.push),
      .wr_addr    (ram_addr),
      .wr_data    (rem_ff),
      .rd_addr    (ram_addr),
      .rd_data_ff (ram_rdata)
   );

   assign status.base_bad    = (req_data.target_base < BASE_MIN) ||
                               (req_data.target_base > BASE_MAX);
   assign status.div_last    = bitcnt_ff == BCW'(VALUE_BITS - 1);
   assign status.quot_zero   = value_ff == '0;
   assign status.stack_empty = count_ff == '0;

   always_comb begin
      if (cmd.emit_err) begin
         rsp_data.digit_char = CHAR_NONE;
         rsp_data.bad_base   = 1'b1;
         rsp_data.last_digit = 1'b1;
      end else begin
         rsp_data.digit_char = digit_to_ascii(ram_rdata);
         rsp_data.bad_base   = 1'b0;
         rsp_data.last_digit = count_ff == '0;
      end
   end

   a_push_room: assert property (@(posedge clock) disable iff (reset)
      cmd.push |-> count_ff < CW'(VALUE_BITS))
      else $error("digit stack overflow");

   a_pop_nonempty: assert property (@(posedge clock) disable iff (reset)
      cmd.pop |-> count_ff != '0)
      else $error("pop from empty digit stack");

   a_rem_below_base: assert property (@(posedge clock) disable iff (reset)
      $past(cmd.div_step) |-> rem_ff < base_ff)
      else $error("remainder not below base");

endmodule

[design/rde_ctrl.sv]
// ----------------------------------------------------------------------------
// rde_ctrl
// Controller: sequences division, stack push, digit emission and the bad-base error result.
// ----------------------------------------------------------------------------
module rde_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   start,
   input  rde_pkg::dp_status_type status,
   output rde_pkg::ctrl_cmd_type  cmd,
   output logic                   busy,
   output logic                   rsp_strobe
);
   import rde_pkg::*;

   state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (start) begin
               state_in = status.base_bad ? ST_ERR : ST_DIV;
            end
         end
         ST_DIV: begin
            if (status.div_last) begin
               state_in = ST_PUSH;
            end
         end
         ST_PUSH: state_in = status.quot_zero ? ST_READ : ST_DIV;
         ST_READ: state_in = ST_EMIT;
         ST_EMIT: state_in = status.stack_empty ? ST_IDLE : ST_READ;
         ST_ERR:  state_in = ST_IDLE;
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      cmd        = '0;
      busy       = 1'b1;
      rsp_strobe = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            busy     = 1'b0;
            cmd.load = start;
         end
         ST_DIV:  cmd.div_step = 1'b1;
         ST_PUSH: cmd.push = 1'b1;
         ST_READ: cmd.pop = 1'b1;
         ST_EMIT: rsp_strobe = 1'b1;
         ST_ERR: begin
            rsp_strobe   = 1'b1;
            cmd.emit_err = 1'b1;
         end
         default: busy = 1'b1;
      endcase
   end

   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> busy)
      else $error("accepted item did not raise busy");

   a_err_single: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_ERR) |=> (state_ff == ST_IDLE))
      else $error("error result not single");

   a_strobe_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> busy)
      else $error("result strobe while idle");

endmodule

[design/radix_digit_emitter.sv]
// ----------------------------------------------------------------------------
// radix_digit_emitter
// Converts a value to ASCII digits in base 2..27, most significant first.
// ----------------------------------------------------------------------------
// Usage:
//   Drive req_data (number_in, target_base) and raise start while busy is
//   low; the item is taken at that clock edge and busy rises.
//   Each digit appears on rsp_data for one cycle with rsp_strobe high,
//   most significant digit first; last_digit marks the final one.
//   A base outside 2..27 gives one result with bad_base and last_digit set
//   and digit_char zero, in the cycle right after the item is taken.
//   Value zero gives the single digit '0'.
// Operation:
//   Each digit is found by a bit-serial restoring divider, one quotient bit
//   per cycle, after which the remainder is pushed onto the digit stack.
//   Emission reads each digit from the stack, then outputs it.
//   busy stays high until the last digit is out; one item at a time.
// Reset:
//   Synchronous, active high; returns to idle and empties the digit stack.
//   Results cannot be held off by the receiver: it must take each strobe.
// ----------------------------------------------------------------------------
module radix_digit_emitter #(
   parameter int VALUE_BITS = rde_pkg::VALUE_BITS_DEF
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   output logic             busy,
   input  rde_pkg::req_type req_data,
   output logic             rsp_strobe,
   output rde_pkg::rsp_type rsp_data
);
   import rde_pkg::*;

   ctrl_cmd_type  cmd;
   dp_status_type status;

   rde_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .status     (status),
      .cmd        (cmd),
      .busy       (busy),
      .rsp_strobe (rsp_strobe)
   );

   rde_dp #(
      .VALUE_BITS (VALUE_BITS)
   ) u_dp (
      .clock    (clock),
      .reset    (reset),
      .req_data (req_data),
      .cmd      (cmd),
      .status   (status),
      .rsp_data (rsp_data)
   );

endmodule

[tb/sv/radix_digit_emitter_tb.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// radix_digit_emitter_tb
// Self-checking testbench for the radix digit emitter. A queue of
// conversion items, filled with a directed set (zero, full-scale values,
// every base edge, bad bases) and then random items, feeds a clocked
// driver. A clocked monitor compares every strobed character against an
// in-bench digit calculator, in order, field by field.
// ----------------------------------------------------------------------------
module radix_digit_emitter_tb;

   import rde_pkg::*;

   localparam int CLK_HALF    = 2;
   localparam int RESET_LEN   = 4;
   localparam int RANDOM_N    = 150;
   localparam int TAIL_CYCLES = 80;
   localparam int CYCLE_LIMIT = 1000000;
   localparam int REPORT_MAX  = 10;

   typedef struct {
      req_type     req;
      int unsigned gap;
      bit          drain;
   } conversion_type;

   logic    clock    = 1'b0;
   logic    reset    = 1'b1;
   logic    start    = 1'b0;
   req_type req_data = '0;
   logic    busy;
   logic    rsp_strobe;
   rsp_type rsp_data;

   conversion_type pending_conversions[$];
   rsp_type        expected_chars[$];

   int unsigned gap_left     = 0;
   int unsigned cur_gap      = 0;
   int unsigned cycle_count  = 0;
   int unsigned error_count  = 0;
   int unsigned items_taken  = 0;
   int unsigned chars_seen   = 0;
   int unsigned bad_items    = 0;
   int unsigned zero_items   = 0;
   int unsigned longest_text = 0;

   radix_digit_emitter dut (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .busy       (busy),
      .req_data   (req_data),
      .rsp_strobe (rsp_strobe),
      .rsp_data   (rsp_data)
   );

   always #(CLK_HALF) clock = ~clock;

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
   end

   // digits of one item, most significant first
   task automatic convert_to_digits(input req_type r);
      logic [DIGIT_W-1:0] digits[NUMBER_W];
      logic [NUMBER_W-1:0] value;
      logic [BASE_W-1:0]   base;
      rsp_type             ch;
      int                  n;
      value = r.number_in;
      base  = r.target_base;
      n     = 0;
      if (base < BASE_MIN || base > BASE_MAX) begin
         ch.digit_char = CHAR_NONE;
         ch.bad_base   = 1'b1;
         ch.last_digit = 1'b1;
         expected_chars.push_back(ch);
         bad_items++;
      end else begin
         if (value == '0) begin
            digits[0] = '0;
            n = 1;
            zero_items++;
         end
         while (value != '0) begin
            digits[n] = DIGIT_W'(value % NUMBER_W'(base));
            value     = value / NUMBER_W'(base);
            n++;
         end
         if (n > longest_text) longest_text = n;
         for (int i = n - 1; i >= 0; i--) begin
            if (digits[i] < DIGIT_W'(10)) begin
               ch.digit_char = CHAR_ZERO + CHAR_W'(digits[i]);
            end else begin
               ch.digit_char = CHAR_A + CHAR_W'(digits[i]) - CHAR_W'(10);
            end
            ch.bad_base   = 1'b0;
            ch.last_digit = (i == 0);
            expected_chars.push_back(ch);
         end
      end
   endtask

   task automatic add_conversion(input logic [NUMBER_W-1:0] number,
                                 input logic [BASE_W-1:0] base,
                                 input int unsigned gap, input bit drain);
      conversion_type c;
      c.req.number_in   = number;
      c.req.target_base = base;
      c.gap             = gap;
      c.drain           = drain;
      pending_conversions.push_back(c);
   endtask

   function automatic int unsigned pick_gap();
      int unsigned r;
      r = $urandom_range(0, 19);
      if (r < 10) return 0;
      if (r < 18) return $urandom_range(1, 4);
      return $urandom_range(20, 150);
   endfunction

   function automatic logic [BASE_W-1:0] pick_base();
      int unsigned r;
      r = $urandom_range(0, 19);
      if (r < 17) return BASE_W'($urandom_range(2, 27));
      if (r < 18) return BASE_W'($urandom_range(0, 1));
      return BASE_W'($urandom_range(28, 255));
   endfunction

   function automatic logic [NUMBER_W-1:0] pick_value(input logic [BASE_W-1:0] base);
      longint unsigned p;
      int unsigned     k;
      int unsigned     r;
      r = $urandom_range(0, 9);
      unique case (r)
         0, 1, 2, 3: return NUMBER_W'($urandom);
         4, 5:       return NUMBER_W'($urandom_range(0, 1000));
         6:          return '0;
         7:          return '1;
         8: begin
            if (base < BASE_MIN || base > BASE_MAX) return NUMBER_W'($urandom);
            p = 1;
            k = $urandom_range(1, 30);
            for (int i = 0; i < k; i++) begin
               if (p * base <= 64'h7FFF_FFFF) p = p * base;
            end
            return $urandom_range(0, 1) ? NUMBER_W'(p) : NUMBER_W'(p - 1);
         end
         default:    return NUMBER_W'($urandom >> $urandom_range(0, 30));
      endcase
   endfunction

   // driver: one item in flight on the request port at a time
   always @(posedge clock) begin
      conversion_type nxt;
      int unsigned    wait_n;
      if (reset) begin
         start    <= 1'b0;
         req_data <= '0;
         gap_left <= 0;
      end else begin
         wait_n = gap_left;
         if (start && !busy) begin
            convert_to_digits(req_data);
            items_taken++;
            wait_n = cur_gap;
         end
         if (!(start && busy)) begin
            if (wait_n > 0) begin
               start    <= 1'b0;
               gap_left <= wait_n - 1;
            end else if (pending_conversions.size() > 0 &&
                         (!pending_conversions[0].drain ||
                          (expected_chars.size() == 0 && !busy))) begin
               nxt = pending_conversions.pop_front();
               req_data <= nxt.req;
               cur_gap  <= nxt.gap;
               start    <= 1'b1;
               gap_left <= 0;
            end else begin
               start    <= 1'b0;
               gap_left <= 0;
            end
         end
      end
   end

   // monitor: every strobe is taken, no hold-off possible
   always @(posedge clock) begin
      rsp_type want;
      if (!reset && rsp_strobe === 1'b1) begin
         chars_seen++;
         if (expected_chars.size() == 0) begin
            error_count++;
            if (error_count <= REPORT_MAX)
               $display("%0t: unexpected char %h bad %b last %b", $realtime,
                        rsp_data.digit_char, rsp_data.bad_base, rsp_data.last_digit);
         end else begin
            want = expected_chars.pop_front();
            if (rsp_data.digit_char !== want.digit_char ||
                rsp_data.bad_base !== want.bad_base ||
                rsp_data.last_digit !== want.last_digit) begin
               error_count++;
               if (error_count <= REPORT_MAX)
                  $display("%0t: mismatch char %h/%h bad %b/%b last %b/%b (exp/got)",
                           $realtime, want.digit_char, rsp_data.digit_char,
                           want.bad_base, rsp_data.bad_base,
                           want.last_digit, rsp_data.last_digit);
            end
         end
      end
   end

   initial begin
      logic [BASE_W-1:0] b;
      // directed items
      add_conversion('0, 8'd2, 0, 1'b0);
      add_conversion('0, 8'd10, 0, 1'b0);
      add_conversion('0, 8'd27, 2, 1'b0);
      add_conversion('1, 8'd2, 0, 1'b0);
      add_conversion('1, 8'd27, 0, 1'b0);
      add_conversion('1, 8'd10, 0, 1'b0);
      add_conversion('1, 8'd16, 3, 1'b0);
      add_conversion(31'd1, 8'd2, 0, 1'b0);
      add_conversion(31'd26, 8'd27, 0, 1'b0);
      add_conversion(31'd27, 8'd27, 0, 1'b0);
      add_conversion(31'd10, 8'd11, 0, 1'b0);
      add_conversion(31'd9, 8'd10, 0, 1'b0);
      add_conversion(31'd35, 8'd28, 0, 1'b0);
      add_conversion('0, 8'd0, 0, 1'b0);
      add_conversion('1, 8'd1, 0, 1'b0);
      add_conversion('1, 8'd255, 0, 1'b0);
      add_conversion(31'h2AAA_AAAA, 8'd3, 40, 1'b0);
      add_conversion(31'h5555_5555, 8'd26, 0, 1'b1);
      add_conversion(31'd387_420_488, 8'd27, 0, 1'b0);
      add_conversion(31'd387_420_489, 8'd27, 0, 1'b0);
      // random items, a few of them wait for the block to drain
      for (int i = 0; i < RANDOM_N; i++) begin
         b = pick_base();
         add_conversion(pick_value(b), b, pick_gap(), $urandom_range(0, 24) == 0);
      end

      repeat (RESET_LEN) @(posedge clock);
      reset <= 1'b0;

      do @(posedge clock);
      while (pending_conversions.size() != 0 || start || expected_chars.size() != 0);
      repeat (TAIL_CYCLES) @(posedge clock);

      $display("%0d items converted, %0d chars checked, %0d bad-base and %0d zero items,",
               items_taken, chars_seen, bad_items, zero_items);
      $display("longest digit string %0d, %0d errors", longest_text, error_count);
      if (error_count == 0) begin
         $display("radix_digit_emitter_tb: clean");
      end else begin
         $display("radix_digit_emitter_tb: errors");
      end
      $finish;
   end

   initial begin
      wait (cycle_count >= CYCLE_LIMIT);
      $display("timeout after %0d cycles, %0d chars still expected",
               cycle_count, expected_chars.size());
      $display("radix_digit_emitter_tb: errors");
      $finish;
   end

endmodule

[filelist.f]
design/rde_pkg.sv
design/rde_ram.sv
design/rde_dp.sv
design/rde_ctrl.sv
design/radix_digit_emitter.sv
tb/sv/radix_digit_emitter_tb.sv
